### rtl/sco_pkg.sv
// Shared types and constants for the sensor clock offset tracker.
// No dependencies; used by the top level, its checker and the testbench.
package sco_pkg;

   localparam int unsigned STAMP_W  = 64;
   localparam int unsigned THRESH_W = 40;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned CSR_W    = 40;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned GAIN_FRAC = 16;

   // register file
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 1'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd10000000000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd328;

   typedef enum logic [1:0] {
      OP_CAMERA      = 2'd0,
      OP_LIDAR_FIRST = 2'd1,
      OP_LIDAR_DYN   = 2'd2,
      OP_ALIGN       = 2'd3
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [STAMP_W-1:0]   stamp;
      logic [STAMP_W-1:0]   host_arrival_time;
   } req_item_type;

   typedef struct packed {
      logic [STAMP_W-1:0]        aligned_stamp;
      logic signed [STAMP_W-1:0] run_offset;
      logic                      locked;
   } rsp_item_type;

endpackage

### rtl/sensor_clock_offset_tracker.sv
// Sensor clock offset tracker: locks and smooths the lidar-to-camera clock
// offset and moves stamps into the camera time domain. Uses sco_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   req     | in        | req_valid / req_stall  | sco_pkg::req_item_type
//   rsp     | out       | rsp_valid / rsp_stall  | sco_pkg::rsp_item_type
//   csr     | in        | csr_write_en (no wait) | csr_index, csr_data
//
// One item per cycle sustained while the result is not stalled. An accepted
// item is held in the input register, then written to the result register
// (the offset update, one 65x17 multiply for the EMA, and the aligned stamp
// are computed in one pass), from which it leaves. The running offset feeds
// straight back, so consecutive items see each other's updates with no bubble.
// Synchronous active-high reset clears all tracking state and restores the
// register defaults. A stalled result holds; the input register takes an
// item whenever it is empty or its own item moves into the result register.
module sensor_clock_offset_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sco_pkg::req_item_type                 req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sco_pkg::rsp_item_type                 rsp_item,
   input  logic                                  csr_write_en,
   input  logic [sco_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sco_pkg::CSR_W-1:0]             csr_data
);

   localparam int unsigned W = sco_pkg::STAMP_W;

   // configuration
   logic [sco_pkg::THRESH_W-1:0] thresh_ff;
   logic [sco_pkg::GAIN_W-1:0]   gain_ff;

   // pipeline control and payload
   logic                  in_valid_ff;
   sco_pkg::req_item_type in_ff;
   logic                  rsp_valid_ff;
   sco_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  advance;

   // tracking state
   logic [W-1:0] latest_cam_ff, latest_cam_in;
   logic [W-1:0] first_cam_ff,  first_cam_in;
   logic [W-1:0] first_lid_ff,  first_lid_in;
   logic         locked_ff,     locked_in;
   logic [W-1:0] init_off_ff,   init_off_in;
   logic [W-1:0] run_off_ff,    run_off_in;

   // datapath
   logic [W-1:0]         cam_cand, lid_cand;
   logic [W-1:0]         dyn_ref, dyn_cur;
   logic [W-1:0]         lock_src, lock_mag, lock_val;
   logic signed [W:0]    ema_diff;
   logic signed [W+sco_pkg::GAIN_W+1:0] ema_prod;
   logic [W-1:0]         ema_next;

   // result register drains or is empty: the update stage may move
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // first stamps as they would stand after this item (zero stays unset)
   assign cam_cand = (first_cam_ff == '0) ? in_ff.stamp : first_cam_ff;
   assign lid_cand = (first_lid_ff == '0) ? in_ff.stamp : first_lid_ff;

   // dynamic lidar sample: against latest camera stamp, else host time
   assign dyn_ref = (latest_cam_ff != '0) ? latest_cam_ff : in_ff.host_arrival_time;
   assign dyn_cur = in_ff.stamp - dyn_ref;

   // lock value, snapped to zero inside the same-domain threshold
   always_comb begin
      unique case (in_ff.operation)
         sco_pkg::OP_CAMERA:      lock_src = first_lid_ff - cam_cand;
         sco_pkg::OP_LIDAR_FIRST: lock_src = lid_cand - first_cam_ff;
         default:                 lock_src = dyn_cur;
      endcase
   end
   assign lock_mag = lock_src[W-1] ? (W'(0) - lock_src) : lock_src;
   assign lock_val = (lock_mag < {{(W-sco_pkg::THRESH_W){1'b0}}, thresh_ff}) ? '0 : lock_src;

   // EMA: running + floor((cur - running) * gain / 2^16), exact 65-bit diff
   assign ema_diff = $signed({dyn_cur[W-1], dyn_cur}) - $signed({run_off_ff[W-1], run_off_ff});
   assign ema_prod = ema_diff * $signed({1'b0, gain_ff});
   assign ema_next = run_off_ff + ema_prod[sco_pkg::GAIN_FRAC +: W];

   always_comb begin
      latest_cam_in = latest_cam_ff;
      first_cam_in  = first_cam_ff;
      first_lid_in  = first_lid_ff;
      locked_in     = locked_ff;
      init_off_in   = init_off_ff;
      run_off_in    = run_off_ff;
      unique case (in_ff.operation)
         sco_pkg::OP_CAMERA: begin
            latest_cam_in = in_ff.stamp;
            if (!locked_ff) begin
               first_cam_in = cam_cand;
               if (first_lid_ff != '0) begin
                  locked_in   = 1'b1;
                  init_off_in = lock_val;
                  run_off_in  = lock_val;
               end
            end
         end
         sco_pkg::OP_LIDAR_FIRST: begin
            if (!locked_ff) begin
               first_lid_in = lid_cand;
               if (first_cam_ff != '0) begin
                  locked_in   = 1'b1;
                  init_off_in = lock_val;
                  run_off_in  = lock_val;
               end
            end
         end
         sco_pkg::OP_LIDAR_DYN: begin
            if (!locked_ff) begin
               locked_in   = 1'b1;
               init_off_in = lock_val;
               run_off_in  = lock_val;
            end else if (init_off_ff != '0) begin
               run_off_in = ema_next;
            end
         end
         sco_pkg::OP_ALIGN: begin
            // query only
         end
      endcase
   end

   // result is taken after the update
   always_comb begin
      rsp_item_in.aligned_stamp = locked_in ? (in_ff.stamp - run_off_in) : in_ff.stamp;
      rsp_item_in.run_offset    = $signed(run_off_in);
      rsp_item_in.locked        = locked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= sco_pkg::THRESH_RESET;
         gain_ff       <= sco_pkg::GAIN_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         latest_cam_ff <= '0;
         first_cam_ff  <= '0;
         first_lid_ff  <= '0;
         locked_ff     <= 1'b0;
         init_off_ff   <= '0;
         run_off_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               sco_pkg::CSR_THRESHOLD: thresh_ff <= csr_data[sco_pkg::THRESH_W-1:0];
               sco_pkg::CSR_GAIN:      gain_ff   <= csr_data[sco_pkg::GAIN_W-1:0];
            endcase
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               latest_cam_ff <= latest_cam_in;
               first_cam_ff  <= first_cam_in;
               first_lid_ff  <= first_lid_in;
               locked_ff     <= locked_in;
               init_off_ff   <= init_off_in;
               run_off_ff    <= run_off_in;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_item;
      end
      if (advance && in_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

### rtl/sco_checker.sv
// Port-level checks for the sensor clock offset tracker, bound to the top.
// Depends on sco_pkg and sensor_clock_offset_tracker.
module sco_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input sco_pkg::rsp_item_type                 rsp_item
);

   // a locked item has been delivered since reset
   logic seen_locked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_locked_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_item.locked) begin
         seen_locked_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_locked_ff |-> rsp_item.locked)
      else $error("lock lost after it was reported");

   a_unlocked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.locked |-> rsp_item.run_offset == '0)
      else $error("nonzero offset before lock");

   a_unlocked_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.locked && seen_locked_ff |-> 1'b0)
      else $error("unlocked item after a locked one");

endmodule

bind sensor_clock_offset_tracker sco_checker u_sco_checker (.*);

### sim/sensor_clock_offset_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sensor_clock_offset_tracker: offset lock, EMA smoothing
// and stamp alignment, under random idling and backpressure. Depends on sco_pkg and the DUT.

class offset_scoreboard;
   logic [63:0] latest_camera;
   logic [63:0] first_camera;
   logic [63:0] first_lidar;
   logic [63:0] initial_offset;
   logic [63:0] running_offset;
   logic        offset_locked;
   logic [39:0] threshold;
   logic [15:0] gain;
   sco_pkg::rsp_item_type aligned_due[$];
   int unsigned fail_count;

   function new();
      latest_camera  = '0;
      first_camera   = '0;
      first_lidar    = '0;
      initial_offset = '0;
      running_offset = '0;
      offset_locked  = 1'b0;
      threshold      = sco_pkg::THRESH_RESET;
      gain           = sco_pkg::GAIN_RESET;
      fail_count     = 0;
   endfunction

   function void set_config(logic [39:0] new_threshold, logic [15:0] new_gain);
      threshold = new_threshold;
      gain      = new_gain;
   endfunction

   // offsets within the threshold collapse to zero (same clock domain)
   function logic [63:0] snap_to_zero(logic [63:0] diff);
      logic [63:0] mag;
      mag = diff[63] ? (64'd0 - diff) : diff;
      return (mag < {24'd0, threshold}) ? 64'd0 : diff;
   endfunction

   // running + floor((cur - running) * gain / 2^16), difference exact in 65 bits
   function logic [63:0] smoothed(logic [63:0] cur);
      logic signed [64:0] d;
      logic signed [16:0] g;
      logic signed [81:0] p;
      d = $signed({cur[63], cur}) - $signed({running_offset[63], running_offset});
      g = $signed({1'b0, gain});
      p = d * g;
      p = p >>> sco_pkg::GAIN_FRAC;
      return running_offset + p[63:0];
   endfunction

   function void lock_pair();
      initial_offset = snap_to_zero(first_lidar - first_camera);
      running_offset = initial_offset;
      offset_locked  = 1'b1;
   endfunction

   function void note_request(sco_pkg::req_item_type it);
      logic [63:0] ref_time;
      logic [63:0] sample;
      sco_pkg::rsp_item_type due;
      case (it.operation)
         sco_pkg::OP_CAMERA: begin
            latest_camera = it.stamp;
            if (!offset_locked) begin
               if (first_camera == 0) first_camera = it.stamp;
               if (first_lidar != 0) lock_pair();
            end
         end
         sco_pkg::OP_LIDAR_FIRST: begin
            if (!offset_locked) begin
               if (first_lidar == 0) first_lidar = it.stamp;
               if (first_camera != 0) lock_pair();
            end
         end
         sco_pkg::OP_LIDAR_DYN: begin
            ref_time = (latest_camera != 0) ? latest_camera : it.host_arrival_time;
            sample   = it.stamp - ref_time;
            if (!offset_locked) begin
               initial_offset = snap_to_zero(sample);
               running_offset = initial_offset;
               offset_locked  = 1'b1;
            end else if (initial_offset != 0) begin
               running_offset = smoothed(sample);
            end
         end
         default: ;
      endcase
      due.aligned_stamp = offset_locked ? (it.stamp - running_offset) : it.stamp;
      due.run_offset    = running_offset;
      due.locked        = offset_locked;
      aligned_due.push_back(due);
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
   endtask

   task check_response(sco_pkg::rsp_item_type got);
      sco_pkg::rsp_item_type due;
      if (aligned_due.size() == 0) begin
         report($sformatf("unexpected item aligned=%h", got.aligned_stamp));
      end else begin
         due = aligned_due.pop_front();
         if (got.aligned_stamp !== due.aligned_stamp)
            report($sformatf("aligned_stamp %h, expected %h",
                             got.aligned_stamp, due.aligned_stamp));
         if (got.run_offset !== due.run_offset)
            report($sformatf("run_offset %h, expected %h",
                             got.run_offset, due.run_offset));
         if (got.locked !== due.locked)
            report($sformatf("locked %b, expected %b", got.locked, due.locked));
      end
   endtask
endclass

module sensor_clock_offset_tracker_tb;

   localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 92;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   sco_pkg::req_item_type         req_item = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   sco_pkg::rsp_item_type         rsp_item;
   logic                          csr_write_en = 1'b0;
   logic [sco_pkg::CSR_IDX_W-1:0] csr_index = sco_pkg::CSR_THRESHOLD;
   logic [sco_pkg::CSR_W-1:0]     csr_data = '0;

   offset_scoreboard sb;

   // stimulus knobs for the sender and the receiver, and the watchdog count
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   int          hold_cycles = 0;
   int          quiet = 0;
   logic [63:0] cam_time;      // camera clock of the synthetic sensor stream
   logic [63:0] lidar_offset;  // true lidar-to-camera offset of that stream
   logic [39:0] thresh_now;

   sensor_clock_offset_tracker dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // corner-heavy value for the noise items
   function automatic logic [63:0] noise_value();
      case ($urandom_range(0, 5))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'h8000_0000_0000_0000;
         3:       return 64'($urandom_range(1, 1000));
         default: return rand64();
      endcase
   endfunction

   // Offer one item; valid stays high after acceptance so back-to-back items
   // need no extra assignment in the same step.
   task automatic send(sco_pkg::op_type op, logic [63:0] stamp, logic [63:0] host);
      int gap;
      sco_pkg::req_item_type it;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.operation         = op;
      it.stamp             = stamp;
      it.host_arrival_time = host;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(it);
   endtask

   // sender pauses until every outstanding item has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.aligned_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // both registers, back to back; the block is idle here
   task automatic write_csrs(logic [39:0] threshold, logic [15:0] gain);
      csr_write_en <= 1'b1;
      csr_index    <= sco_pkg::CSR_THRESHOLD;
      csr_data     <= threshold;
      @(posedge clock);
      csr_index    <= sco_pkg::CSR_GAIN;
      csr_data     <= {24'd0, gain};
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      sb.set_config(threshold, gain);
      thresh_now = threshold;
   endtask

   function automatic logic [39:0] pick_threshold(int sel);
      case (sel % 4)
         0:       return 40'd0;
         1:       return '1;
         2:       return sco_pkg::THRESH_RESET;
         default: return 40'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 8);
      endcase
   endfunction

   // Lock happens once per run, so the path is left to the seed: pair within
   // the threshold, pair exactly at it, arbitrary pair, or a dynamic event
   // with and without a camera stamp to refer to.
   task automatic lock_offset();
      int          path;
      logic [63:0] base;
      logic [63:0] delta;
      path = $urandom_range(0, 4);
      base = {4'h1, 28'($urandom), $urandom};
      case (path)
         0:       delta = (thresh_now != 0) ? rand64() % {24'd0, thresh_now} : 64'd0;
         1:       delta = {24'd0, thresh_now};
         default: delta = $urandom_range(0, 1) ? {24'd0, thresh_now} + $urandom : rand64();
      endcase
      if ($urandom_range(0, 1)) delta = 64'd0 - delta;
      case (path)
         3: send(sco_pkg::OP_LIDAR_DYN, base + delta, base);  // no camera yet: host time is ref
         4: begin
            send(sco_pkg::OP_CAMERA, base, rand64());
            send(sco_pkg::OP_LIDAR_DYN, base + delta, rand64());
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               send(sco_pkg::OP_CAMERA, base, rand64());
               send(sco_pkg::OP_LIDAR_FIRST, base + delta, rand64());
            end else begin
               send(sco_pkg::OP_LIDAR_FIRST, base + delta, rand64());
               send(sco_pkg::OP_CAMERA, base, rand64());
            end
         end
      endcase
      cam_time     = base;
      lidar_offset = delta;
   endtask

   task automatic directed();
      // before lock: alignment passes stamps through, zero stamps stay unset
      send(sco_pkg::OP_ALIGN, '1, '1);
      send(sco_pkg::OP_ALIGN, 64'd0, 64'd0);
      send(sco_pkg::OP_CAMERA, 64'd0, '1);
      send(sco_pkg::OP_LIDAR_FIRST, 64'd0, 64'd0);
      send(sco_pkg::OP_ALIGN, 64'h8000_0000_0000_0000, rand64());
      lock_offset();
      // after lock
      send(sco_pkg::OP_ALIGN, '1, 64'd0);
      send(sco_pkg::OP_ALIGN, 64'd0, '1);
      send(sco_pkg::OP_LIDAR_FIRST, rand64(), rand64());    // ignored once locked
      send(sco_pkg::OP_CAMERA, cam_time + 64'd1_000_000, rand64());
      send(sco_pkg::OP_LIDAR_DYN, cam_time + lidar_offset + 64'd1_000_123, rand64());
      send(sco_pkg::OP_CAMERA, 64'd0, rand64());            // latest camera cleared
      send(sco_pkg::OP_LIDAR_DYN, cam_time + lidar_offset, cam_time); // host time as ref
      send(sco_pkg::OP_LIDAR_DYN, '1, 64'd0);
      send(sco_pkg::OP_LIDAR_DYN, 64'd0, '1);
      send(sco_pkg::OP_CAMERA, '1, 64'd0);
      send(sco_pkg::OP_LIDAR_DYN, 64'd0, 64'd0);
      send(sco_pkg::OP_LIDAR_DYN, 64'h8000_0000_0000_0000, rand64());
      send(sco_pkg::OP_CAMERA, cam_time + 64'd2_000_000, rand64());
      send(sco_pkg::OP_ALIGN, cam_time + lidar_offset, rand64());
   endtask

   // Mostly a plausible sensor stream (camera frames with lidar sweeps at a
   // slowly drifting offset), the rest noise with corner values.
   task automatic random_item();
      logic [63:0] jitter;
      int          kind;
      jitter = {44'd0, 20'($urandom)};
      if ($urandom_range(0, 1)) jitter = 64'd0 - jitter;
      if ($urandom_range(0, 99) < 75) begin
         cam_time = cam_time + $urandom_range(1_000_000, 50_000_000);
         if ($urandom_range(0, 7) == 0)
            lidar_offset = lidar_offset + 64'($urandom_range(0, 2000)) - 64'd1000;
         kind = $urandom_range(0, 9);
         if (kind < 4)
            send(sco_pkg::OP_CAMERA, cam_time, rand64());
         else if (kind < 8)
            send(sco_pkg::OP_LIDAR_DYN, cam_time + lidar_offset + jitter,
                 cam_time + $urandom_range(0, 5_000_000));
         else if (kind == 8)
            send(sco_pkg::OP_ALIGN, cam_time + lidar_offset + jitter, rand64());
         else
            send(sco_pkg::OP_LIDAR_FIRST, cam_time + lidar_offset, rand64());
      end else begin
         send(sco_pkg::op_type'($urandom_range(0, 3)), noise_value(), noise_value());
      end
   endtask

   // receiver: random stall per item, or a long hold when one is requested
   initial begin
      int n;
      forever begin
         n = (hold_cycles != 0) ? hold_cycles : (recv_idle ? $urandom_range(0, 13) : 0);
         hold_cycles = 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         sb.check_response(rsp_item);
      end
   end

   // watchdog: too long with no item moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      thresh_now = sco_pkg::THRESH_RESET;
      cam_time = 64'd1;
      lidar_offset = 64'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold only matters up to lock, so the seed picks it here
      write_csrs(pick_threshold($urandom_range(0, 3)), 16'($urandom));
      directed();

      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         case (phase)
            1: write_csrs(pick_threshold(phase), 16'hFFFF);
            2: write_csrs(pick_threshold(phase), 16'd0);
            3: write_csrs(pick_threshold(phase), 16'd1);
            4: write_csrs(pick_threshold(phase), sco_pkg::GAIN_RESET);
            default: write_csrs(pick_threshold(phase), 16'($urandom));
         endcase
         send_idle = !(phase == 2 || phase == 3);
         recv_idle = (phase != 2);
         // long receiver hold while the sender keeps offering: fills the block
         if (phase == 3 || phase == 5) hold_cycles = 150;
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sensor_clock_offset_tracker.f
rtl/sco_pkg.sv
rtl/sensor_clock_offset_tracker.sv
rtl/sco_checker.sv
sim/sensor_clock_offset_tracker_tb.sv
